// ===== rtl/tria_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tria_pkg: shared types and constants of the two-resource interval assigner
// Sizes, the sort key layout, the sequencer states and the bundles that run
// between the controller, the interval store and the key comparator.
// ----------------------------------------------------------------------------
package tria_pkg;

  // capacity of one set and width of a stored time
  localparam int MAX_INTERVALS = 64;
  localparam int TIME_BITS     = 16;

  // fixed port field widths
  localparam int IN_TIME_W  = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 8;

  localparam int IDX_W = $clog2(MAX_INTERVALS);
  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam cnt_t MAX_CNT = cnt_t'(MAX_INTERVALS);

  // sort key: start, then end, then arrival index (most significant first)
  typedef struct packed {
    time_t st_time;
    time_t en_time;
    idx_t  idx;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_PICK,
    ST_EMIT_RD,
    ST_EMIT,
    ST_FAIL
  } state_t;

  // controller to store
  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    time_t wr_st;
    time_t wr_en_time;
    idx_t  rd_addr;
    logic  bit_wr_en;
    idx_t  bit_wr_addr;
    logic  bit_wr_data;
    idx_t  bit_rd_addr;
  } store_req_t;

  // store to controller, registered read data
  typedef struct packed {
    time_t rd_st;
    time_t rd_en_time;
    logic  bit_rd_data;
  } store_rsp_t;

  // one result item
  typedef struct packed {
    logic resource;
    logic impossible;
    logic last;
  } result_t;

  // port time field to stored time: drop bits above TIME_BITS, zero-extend below
  function automatic time_t to_time(logic [IN_TIME_W-1:0] v);
    logic [TIME_BITS+IN_TIME_W-1:0] ext;
    ext = {{TIME_BITS{1'b0}}, v};
    return ext[TIME_BITS-1:0];
  endfunction

endpackage

// ===== rtl/tria_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tria_store: interval and assignment memories
// Start and end times by arrival index, one write and one read port, plus a
// one-bit memory of chosen resources. All read data is registered.
// ----------------------------------------------------------------------------
module tria_store
  import tria_pkg::*;
(
  input  logic       clk,
  input  store_req_t req,
  output store_rsp_t rsp
);

  time_t st_mem  [MAX_INTERVALS];
  time_t en_mem  [MAX_INTERVALS];
  logic  bit_mem [MAX_INTERVALS];

  // interval memory
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      st_mem[req.wr_addr] <= req.wr_st;
      en_mem[req.wr_addr] <= req.wr_en_time;
    end
    rsp.rd_st      <= st_mem[req.rd_addr];
    rsp.rd_en_time <= en_mem[req.rd_addr];
  end

  // assignment memory
  always_ff @(posedge clk) begin
    if (req.bit_wr_en) begin
      bit_mem[req.bit_wr_addr] <= req.bit_wr_data;
    end
    rsp.bit_rd_data <= bit_mem[req.bit_rd_addr];
  end

endmodule

// ===== rtl/tria_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tria_cmp: shared sort key comparator
// Tells whether a candidate key lies above the last placed key and below the
// best key found so far in the current scan.
// ----------------------------------------------------------------------------
module tria_cmp
  import tria_pkg::*;
(
  input  key_t cand,
  input  key_t prev,
  input  logic prev_vld,
  input  key_t best,
  input  logic best_vld,
  output logic take
);

  logic [KEY_W-1:0] cand_v;
  logic [KEY_W-1:0] prev_v;
  logic [KEY_W-1:0] best_v;
  logic             above_prev;
  logic             below_best;

  assign cand_v = cand;
  assign prev_v = prev;
  assign best_v = best;

  // keys are unique, so strict compares order every pair
  assign above_prev = !prev_vld || (cand_v > prev_v);
  assign below_best = !best_vld || (cand_v < best_v);
  assign take       = above_prev && below_best;

endmodule

// ===== rtl/tria_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tria_ctrl: load, order and assign sequencer
// Loads intervals, then for each rank scans the store for the next key in
// order through the shared comparator, places it greedily on A or B, and
// finally reads back one assignment bit per interval; an overflow or a misfit gives a failure result.
// ----------------------------------------------------------------------------
module tria_ctrl
  import tria_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // interval transactions
  input  logic       in_valid,
  output logic       in_ready,
  input  time_t      in_start,
  input  time_t      in_end,
  input  logic       in_last,
  // store
  output store_req_t req,
  input  store_rsp_t rsp,
  // comparator
  output key_t       cmp_cand,
  output key_t       cmp_prev,
  output logic       cmp_prev_vld,
  output key_t       cmp_best,
  output logic       cmp_best_vld,
  input  logic       cmp_take,
  // results
  output logic       res_valid,
  input  logic       res_ready,
  output result_t    res
);

  state_t state_r, state_nxt;
  cnt_t   count_r, count_nxt;
  logic   ovf_r, ovf_nxt;
  cnt_t   scan_r, scan_nxt;
  cnt_t   rank_r, rank_nxt;
  cnt_t   out_idx_r, out_idx_nxt;
  logic   rd_vld_r, rd_vld_nxt;
  idx_t   rd_idx_r, rd_idx_nxt;
  key_t   prev_key_r, prev_key_nxt;
  logic   prev_vld_r, prev_vld_nxt;
  key_t   best_key_r, best_key_nxt;
  logic   best_vld_r, best_vld_nxt;
  time_t  free_a_r, free_a_nxt;
  time_t  free_b_r, free_b_nxt;

  logic   fit_a;
  logic   fit_b;
  logic   set_full;
  logic   scan_more;
  logic   emit_last;
  logic   pick_last;

  // status terms
  assign fit_a     = (free_a_r <= best_key_r.st_time);
  assign fit_b     = (free_b_r <= best_key_r.st_time);
  assign set_full  = ovf_r || (count_r == MAX_CNT);
  assign scan_more = (scan_r < count_r);
  assign emit_last = (cnt_t'(out_idx_r + 1'b1) == count_r);
  assign pick_last = (cnt_t'(rank_r + 1'b1) == count_r);

  // comparator operands
  assign cmp_cand     = '{st_time: rsp.rd_st, en_time: rsp.rd_en_time, idx: rd_idx_r};
  assign cmp_prev     = prev_key_r;
  assign cmp_prev_vld = prev_vld_r;
  assign cmp_best     = best_key_r;
  assign cmp_best_vld = best_vld_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last) begin
          state_nxt = set_full ? ST_FAIL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_more && !rd_vld_r) begin
          state_nxt = ST_PICK;
        end
      end
      ST_PICK: begin
        if (!fit_a && !fit_b) begin
          state_nxt = ST_FAIL;
        end else if (pick_last) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (res_ready) begin
          state_nxt = emit_last ? ST_LOAD : ST_EMIT_RD;
        end
      end
      ST_FAIL: begin
        if (res_ready) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // handshake and result outputs
  always_comb begin
    in_ready       = 1'b0;
    res_valid      = 1'b0;
    res.resource   = 1'b0;
    res.impossible = 1'b0;
    res.last       = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
      end
      ST_EMIT: begin
        res_valid    = 1'b1;
        res.resource = rsp.bit_rd_data;
        res.last     = emit_last;
      end
      ST_FAIL: begin
        res_valid      = 1'b1;
        res.impossible = 1'b1;
        res.last       = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // datapath and store requests
  always_comb begin
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    scan_nxt     = scan_r;
    rank_nxt     = rank_r;
    out_idx_nxt  = out_idx_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    prev_key_nxt = prev_key_r;
    prev_vld_nxt = prev_vld_r;
    best_key_nxt = best_key_r;
    best_vld_nxt = best_vld_r;
    free_a_nxt   = free_a_r;
    free_b_nxt   = free_b_r;

    req.wr_en       = 1'b0;
    req.wr_addr     = count_r[IDX_W-1:0];
    req.wr_st       = in_start;
    req.wr_en_time  = in_end;
    req.rd_addr     = scan_r[IDX_W-1:0];
    req.bit_wr_en   = 1'b0;
    req.bit_wr_addr = best_key_r.idx;
    req.bit_wr_data = 1'b0;
    req.bit_rd_addr = out_idx_r[IDX_W-1:0];

    case (state_r)
      // store while there is room, otherwise remember the overflow
      ST_LOAD: begin
        if (in_valid) begin
          if (count_r < MAX_CNT) begin
            req.wr_en = 1'b1;
            count_nxt = cnt_t'(count_r + 1'b1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            scan_nxt     = '0;
            rank_nxt     = '0;
            prev_vld_nxt = 1'b0;
            best_vld_nxt = 1'b0;
            free_a_nxt   = '0;
            free_b_nxt   = '0;
          end
        end
      end
      // walk the store, keep the smallest key above the last placed one
      ST_SCAN: begin
        rd_vld_nxt = scan_more;
        rd_idx_nxt = scan_r[IDX_W-1:0];
        if (scan_more) begin
          scan_nxt = cnt_t'(scan_r + 1'b1);
        end
        if (rd_vld_r && cmp_take) begin
          best_key_nxt = cmp_cand;
          best_vld_nxt = 1'b1;
        end
      end
      // greedy placement of the found interval
      ST_PICK: begin
        if (fit_a) begin
          req.bit_wr_en   = 1'b1;
          req.bit_wr_data = 1'b0;
          free_a_nxt      = best_key_r.en_time;
        end else if (fit_b) begin
          req.bit_wr_en   = 1'b1;
          req.bit_wr_data = 1'b1;
          free_b_nxt      = best_key_r.en_time;
        end
        prev_key_nxt = best_key_r;
        prev_vld_nxt = 1'b1;
        best_vld_nxt = 1'b0;
        rank_nxt     = cnt_t'(rank_r + 1'b1);
        scan_nxt     = '0;
        out_idx_nxt  = '0;
      end
      // hand out bits in arrival order, clear the set after the last
      ST_EMIT: begin
        if (res_ready) begin
          if (emit_last) begin
            count_nxt  = '0;
            ovf_nxt    = 1'b0;
            free_a_nxt = '0;
            free_b_nxt = '0;
          end else begin
            out_idx_nxt = cnt_t'(out_idx_r + 1'b1);
          end
        end
      end
      ST_FAIL: begin
        if (res_ready) begin
          count_nxt  = '0;
          ovf_nxt    = 1'b0;
          free_a_nxt = '0;
          free_b_nxt = '0;
        end
      end
      default: begin
        rd_vld_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      scan_r     <= '0;
      rank_r     <= '0;
      out_idx_r  <= '0;
      rd_vld_r   <= 1'b0;
      prev_vld_r <= 1'b0;
      best_vld_r <= 1'b0;
      free_a_r   <= '0;
      free_b_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      scan_r     <= scan_nxt;
      rank_r     <= rank_nxt;
      out_idx_r  <= out_idx_nxt;
      rd_vld_r   <= rd_vld_nxt;
      prev_vld_r <= prev_vld_nxt;
      best_vld_r <= best_vld_nxt;
      free_a_r   <= free_a_nxt;
      free_b_r   <= free_b_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    prev_key_r <= prev_key_nxt;
    best_key_r <= best_key_nxt;
  end

`ifndef ASSERT_OFF
  // fill count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("interval count above capacity");

  // a scan always ends with a candidate
  a_pick_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PICK |-> best_vld_r)
    else $error("placement without a found interval");

  // emitted index stays inside the stored set
  a_emit_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> out_idx_r < count_r)
    else $error("emit index beyond stored set");

  // read data is only tagged valid during a scan
  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r) == ST_SCAN)
    else $error("store read outside scan");
`endif

endmodule

// ===== rtl/two_resource_interval_assigner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_resource_interval_assigner: greedy interval partitioning on two resources
// Collects a set of intervals, orders them by start, end and arrival, places
// each on A or B and returns one resource bit per interval, or one failure result.
//
//   channel  dir  tdata                     tuser        tlast
//   in_      in   start_time, end_time      -            last_interval
//   out_     out  resource (7 bits pad)     impossible   last_result
//
// intervals are stored as they are accepted; after the last one each of the n
// ranks costs a full store scan plus a placement state, and ordering and
// placement are paced by the single store read port feeding the shared
// key comparator
// each result takes an assignment memory read, then an offer
// reset is synchronous; the stores need no clearing pass
// an output register holds each result, so a stalled out_tready stops the
// sequencer only once that register is full; in_tready is low until the
// previous set has been fully delivered into it
// ----------------------------------------------------------------------------
module two_resource_interval_assigner
  import tria_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // interval transactions
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] start_time, [31:16] end_time
  input  logic                  in_tlast,
  // result transactions
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [0] resource, [7:1] zero
  output logic [0:0]            out_tuser,  // [0] impossible
  output logic                  out_tlast
);

  store_req_t req;
  store_rsp_t rsp;
  key_t       cmp_cand;
  key_t       cmp_prev;
  logic       cmp_prev_vld;
  key_t       cmp_best;
  logic       cmp_best_vld;
  logic       cmp_take;
  logic       res_valid;
  logic       res_ready;
  result_t    res;
  time_t      in_start;
  time_t      in_end;

  logic       out_valid_r;
  result_t    out_res_r;

  // unpack input fields
  assign in_start = to_time(in_tdata[IN_TIME_W-1:0]);
  assign in_end   = to_time(in_tdata[2*IN_TIME_W-1:IN_TIME_W]);

  tria_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_start     (in_start),
    .in_end       (in_end),
    .in_last      (in_tlast),
    .req          (req),
    .rsp          (rsp),
    .cmp_cand     (cmp_cand),
    .cmp_prev     (cmp_prev),
    .cmp_prev_vld (cmp_prev_vld),
    .cmp_best     (cmp_best),
    .cmp_best_vld (cmp_best_vld),
    .cmp_take     (cmp_take),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  tria_store u_store (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  tria_cmp u_cmp (
    .cand     (cmp_cand),
    .prev     (cmp_prev),
    .prev_vld (cmp_prev_vld),
    .best     (cmp_best),
    .best_vld (cmp_best_vld),
    .take     (cmp_take)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  // pack result fields
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, out_res_r.resource};
  assign out_tuser  = out_res_r.impossible;
  assign out_tlast  = out_res_r.last;

endmodule

// ===== tb/tb_two_resource_interval_assigner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_resource_interval_assigner: self-checking bench for the assigner
// Interval sets are queued by a stimulus block and sent by a clocked driver.
// Each accepted interval also goes into a local copy of the set. On the last
// interval the bench orders the set, places it on the two resources and
// queues the expected results. A clocked monitor compares every result
// transaction with the oldest expected result. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_two_resource_interval_assigner;
  import tria_pkg::*;

  localparam int TOTAL_ITEMS = 350;
  localparam int RUN_LIMIT   = 500000;
  localparam int DRAIN_WAIT  = 100;
  localparam int MAX_REPORTS = 10;

  // one queued interval with its pacing controls
  typedef struct {
    logic [IN_TIME_W-1:0] st;
    logic [IN_TIME_W-1:0] en;
    logic                 lst;
    logic                 hold;
    int                   phase;
  } pend_iv_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;

  // stimulus and expected results
  pend_iv_t interval_q[$];
  result_t  placement_q[$];
  pend_iv_t cur_iv;
  int       run_phase = 0;
  int       push_cnt = 0;
  logic     fill_hold = 1'b0;
  int       mismatch_cnt = 0;
  int       cycle_cnt = 0;

  // idle percentages per phase
  int send_idle_pct[3] = '{31, 58, 0};
  int recv_idle_pct[3] = '{58, 31, 0};

  // local copy of the set being collected
  time_t set_st[MAX_INTERVALS];
  time_t set_en[MAX_INTERVALS];
  int    set_len = 0;
  logic  set_overflow = 1'b0;

  two_resource_interval_assigner i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] start_time, [31:16] end_time
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] resource, [7:1] zero
    .out_tuser  (out_tuser),  // [0] impossible
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  // ordering: start, then end, then arrival
  function automatic bit orders_first(int x, int y);
    if (set_st[x] != set_st[y]) return set_st[x] < set_st[y];
    if (set_en[x] != set_en[y]) return set_en[x] < set_en[y];
    return x < y;
  endfunction

  // collect one interval; on the last one place the set and queue results
  task automatic take_interval(input time_t st, input time_t en, input logic lst);
    int      order[MAX_INTERVALS];
    logic    on_b[MAX_INTERVALS];
    int      i;
    int      k;
    int      cur;
    time_t   free_a;
    time_t   free_b;
    logic    blocked;
    result_t r;
    if (set_len < MAX_INTERVALS) begin
      set_st[set_len] = st;
      set_en[set_len] = en;
      set_len++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!lst) return;
    blocked = set_overflow;
    if (!blocked) begin
      // insertion sort of arrival indices
      for (i = 0; i < set_len; i++) order[i] = i;
      for (i = 1; i < set_len; i++) begin
        cur = order[i];
        k = i;
        while (k > 0 && orders_first(cur, order[k-1])) begin
          order[k] = order[k-1];
          k--;
        end
        order[k] = cur;
      end
      // greedy placement, resource a first
      free_a = '0;
      free_b = '0;
      for (i = 0; i < set_len && !blocked; i++) begin
        cur = order[i];
        if (free_a <= set_st[cur]) begin
          on_b[cur] = 1'b0;
          free_a = set_en[cur];
        end else if (free_b <= set_st[cur]) begin
          on_b[cur] = 1'b1;
          free_b = set_en[cur];
        end else begin
          blocked = 1'b1;
        end
      end
    end
    if (blocked) begin
      r.resource   = 1'b0;
      r.impossible = 1'b1;
      r.last       = 1'b1;
      placement_q.insert(placement_q.size(), r);
    end else begin
      for (i = 0; i < set_len; i++) begin
        r.resource   = on_b[i];
        r.impossible = 1'b0;
        r.last       = (i == set_len - 1);
        placement_q.insert(placement_q.size(), r);
      end
    end
    set_len = 0;
    set_overflow = 1'b0;
  endtask

  // queue one interval for the driver
  task automatic push_iv(input logic [IN_TIME_W-1:0] s, input logic [IN_TIME_W-1:0] e,
                         input logic lst);
    pend_iv_t p;
    p.st    = s;
    p.en    = e;
    p.lst   = lst;
    p.hold  = fill_hold;
    p.phase = (push_cnt * 3 / TOTAL_ITEMS > 2) ? 2 : push_cnt * 3 / TOTAL_ITEMS;
    fill_hold = 1'b0;
    push_cnt++;
    interval_q.insert(interval_q.size(), p);
  endtask

  // a set built from a few chains of intervals, or with fully random times,
  // sent in shuffled arrival order
  task automatic gen_set(input int n, input int lanes, input bit wide);
    logic [IN_TIME_W-1:0] st_a[];
    logic [IN_TIME_W-1:0] en_a[];
    logic [IN_TIME_W-1:0] tmp;
    int lane_end[3];
    int base;
    int j;
    int c;
    int s;
    int len;
    st_a = new[n];
    en_a = new[n];
    base = $urandom_range(0, 60000);
    for (c = 0; c < 3; c++) lane_end[c] = base + $urandom_range(0, 40);
    for (j = 0; j < n; j++) begin
      if (wide) begin
        st_a[j] = IN_TIME_W'($urandom);
        en_a[j] = IN_TIME_W'($urandom);
      end else begin
        c = $urandom_range(0, lanes - 1);
        s = lane_end[c] + $urandom_range(0, 12);
        st_a[j] = s[IN_TIME_W-1:0];
        if ($urandom_range(0, 19) == 0) begin
          // end before start
          len = s - $urandom_range(1, 8);
          en_a[j] = len[IN_TIME_W-1:0];
        end else begin
          len = s + $urandom_range(0, 30);
          en_a[j] = len[IN_TIME_W-1:0];
          lane_end[c] = len;
        end
      end
    end
    for (j = n - 1; j > 0; j--) begin
      c = $urandom_range(0, j);
      tmp = st_a[j]; st_a[j] = st_a[c]; st_a[c] = tmp;
      tmp = en_a[j]; en_a[j] = en_a[c]; en_a[c] = tmp;
    end
    for (j = 0; j < n; j++) push_iv(st_a[j], en_a[j], j == n - 1);
  endtask

  // driver: holds tvalid until accepted, idles at random between transactions
  always @(posedge clk) begin : drive_proc
    logic drive_v;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      drive_v = in_tvalid;
      if (in_tvalid && in_tready) begin
        take_interval(time_t'(cur_iv.st), time_t'(cur_iv.en), cur_iv.lst);
        drive_v = 1'b0;
      end
      if (!drive_v && interval_q.size() > 0) begin
        if (!(interval_q[0].hold && placement_q.size() > 0) &&
            $urandom_range(0, 99) >= send_idle_pct[interval_q[0].phase]) begin
          cur_iv = interval_q.pop_front();
          run_phase = cur_iv.phase;
          in_tdata <= {cur_iv.en, cur_iv.st};
          in_tlast <= cur_iv.lst;
          drive_v = 1'b1;
        end
      end
      in_tvalid <= drive_v;
    end
  end

  // monitor: compares each result transaction with the oldest expectation
  always @(posedge clk) begin : check_proc
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (placement_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result: resource %0d impossible %0d last %0d",
                     $realtime, out_tdata, out_tuser[0], out_tlast);
        end else begin
          want = placement_q.pop_front();
          if (out_tdata !== {{(OUT_DATA_W-1){1'b0}}, want.resource} ||
              out_tuser[0] !== want.impossible || out_tlast !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("%0t: mismatch: expected resource %0d impossible %0d last %0d, %s %0d %0d %0d",
                       $realtime, want.resource, want.impossible, want.last,
                       "got", out_tdata, out_tuser[0], out_tlast);
          end
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct[run_phase]);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    bit big_done;
    bit over_done;
    int pick;
    big_done = 1'b0;
    over_done = 1'b0;

    // single intervals at the field extremes, end before start included
    push_iv(16'h0000, 16'h0000, 1'b1);
    push_iv(16'hffff, 16'hffff, 1'b1);
    push_iv(16'hffff, 16'h0000, 1'b1);
    // three full-range overlaps cannot fit on two resources
    push_iv(16'h0000, 16'hffff, 1'b0);
    push_iv(16'h0000, 16'hffff, 1'b0);
    push_iv(16'h0000, 16'hffff, 1'b1);
    // equal keys fall back to arrival order, touching ends share a resource
    push_iv(16'd5, 16'd9, 1'b0);
    push_iv(16'd5, 16'd9, 1'b0);
    push_iv(16'd9, 16'd12, 1'b0);
    push_iv(16'd9, 16'd9, 1'b1);
    // end before start inside a set
    push_iv(16'd10, 16'd3, 1'b0);
    push_iv(16'd2, 16'd20, 1'b0);
    push_iv(16'd4, 16'd5, 1'b1);
    // an unused resource takes any start
    push_iv(16'd0, 16'd5, 1'b0);
    push_iv(16'd1, 16'd2, 1'b1);

    // random sets, one full set and one over capacity among them
    fill_hold = 1'b1;
    while (push_cnt < TOTAL_ITEMS) begin
      if (!big_done && push_cnt >= 70) begin
        big_done = 1'b1;
        gen_set(MAX_INTERVALS, 2, 1'b0);
      end else if (!over_done && push_cnt >= 200) begin
        over_done = 1'b1;
        fill_hold = 1'b1;
        gen_set(MAX_INTERVALS + 1, 2, 1'b0);
      end else begin
        if ($urandom_range(0, 11) == 0) fill_hold = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 55)      gen_set($urandom_range(1, 8), $urandom_range(1, 2), 1'b0);
        else if (pick < 75) gen_set($urandom_range(1, 6), 2, 1'b1);
        else if (pick < 85) gen_set($urandom_range(1, 2), 2, 1'b1);
        else                gen_set($urandom_range(3, 8), 3, 1'b0);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // wait for all stimulus and results, then let the block settle
    while (interval_q.size() > 0 || in_tvalid || placement_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    mismatch_cnt = mismatch_cnt + placement_q.size();
    if (mismatch_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== two_resource_interval_assigner.f =====
rtl/tria_pkg.sv
rtl/tria_store.sv
rtl/tria_cmp.sv
rtl/tria_ctrl.sv
rtl/two_resource_interval_assigner.sv
tb/tb_two_resource_interval_assigner.sv
